[hdl/wspc_pkg.sv]
// Shared types and constants for the wheel speed PID controller.
// No dependencies; every other file in hdl imports this package.
package wspc_pkg;

	localparam int PULSE_W  = 32;
	localparam int US_W     = 24;
	localparam int POWER_W  = 10;
	localparam int SPEED_W  = 16;
	localparam int TARGET_W = 13;
	localparam int GAIN_W   = 24;
	localparam int SCALE_W  = 32;
	localparam int MSPEED_W = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MSPEED = 3'd6;

	localparam logic [SCALE_W-1:0] SCALE_RESET  = 32'h0001_0000;
	localparam logic [19:0]        USEC_PER_SEC = 20'd1_000_000;
	localparam logic [25:0]        POWER_MAX    = 26'd67_043_328;  // 1023.0 in Q10.16
	localparam logic [60:0]        I_LIMIT      = 61'h1000_0000_0000_0000;
	localparam logic [POWER_W-1:0] MPOWER_MAX   = 10'd1023;

	// Shared sequential divider.
	localparam int DIV_REM_W = 40;
	localparam int DIV_NUM_W = 43;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] SPD_STEPS = 6'd16;
	localparam logic [DIV_CNT_W-1:0] DER_STEPS = 6'd43;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PROD,
		OP_NORM,
		OP_SDIV,
		OP_TAKE_SPD,
		OP_ERR,
		OP_EMUL,
		OP_INTEG,
		OP_IMUL,
		OP_ICOMB,
		OP_TAKE_D,
		OP_SUM
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic manual;
		logic div_busy;
	} sts_t;

endpackage

[hdl/wspc_if.sv]
// Channel interfaces of the wheel speed PID controller: tick, result, config.
// Depends on wspc_pkg for the field widths.
interface wspc_tick_if import wspc_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_total;
	logic [US_W-1:0]    elapsed_us;

	modport source (output valid, output pulse_total, output elapsed_us, input ready);
	modport sink (input valid, input pulse_total, input elapsed_us, output ready);
endinterface

interface wspc_result_if import wspc_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [POWER_W-1:0] motor_power;
	logic               motor_reverse;
	logic [SPEED_W-1:0] measured_speed;

	modport source (output valid, output motor_power, output motor_reverse,
		output measured_speed, input ready);
	modport sink (input valid, input motor_power, input motor_reverse,
		input measured_speed, output ready);
endinterface

interface wspc_cfg_if import wspc_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/wspc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on wspc_pkg for its widths.
module wspc_div import wspc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_REM_W-1:0] rem_init,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_REM_W-1:0] divisor,
	input  logic [DIV_CNT_W-1:0] steps,
	output logic                 busy,
	output logic [DIV_NUM_W-1:0] quo
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_REM_W-1:0] dvs_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_REM_W:0]   trial;
	logic [DIV_REM_W+1:0] diff;

	always_comb begin
		trial = {rem_q, num_q[DIV_NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvs_q <= divisor;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			// A clear borrow bit means the trial remainder reached the divisor.
			if (!diff[DIV_REM_W+1]) begin
				rem_q <= diff[DIV_REM_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_REM_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

[hdl/wspc_datapath.sv]
// Datapath of the wheel speed PID controller: configuration and controller
// state, work registers, multipliers and the shared divider (wspc_div).
module wspc_datapath import wspc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PULSE_W-1:0]    pulse_total,
	input  logic [US_W-1:0]       elapsed_us,
	output sts_t                  sts,
	output logic [POWER_W-1:0]    motor_power,
	output logic                  motor_reverse,
	output logic [SPEED_W-1:0]    measured_speed
);

	// Configuration registers.
	logic signed [TARGET_W-1:0] target_q;
	logic signed [GAIN_W-1:0]   gain_p_q;
	logic signed [GAIN_W-1:0]   gain_i_q;
	logic signed [GAIN_W-1:0]   gain_d_q;
	logic [SCALE_W-1:0]         scale_q;
	logic                       manual_q;
	logic signed [MSPEED_W-1:0] mspeed_q;

	// Controller state kept between ticks.
	logic [PULSE_W-1:0] prev_pulse_q;
	logic signed [47:0] integ_q;
	logic signed [17:0] prev_err_q;
	logic [25:0]        power_q;

	// Work registers of one tick.
	logic [PULSE_W-1:0] dp_q;
	logic [US_W-1:0]    us_q;
	logic [63:0]        prod_q;
	logic               sat1_q;
	logic [59:0]        n_q;
	logic               sat_q;
	logic [SPEED_W-1:0] spd_q;
	logic signed [17:0] e_q;
	logic signed [42:0] eu_q;
	logic signed [41:0] p_q;
	logic signed [18:0] de_q;
	logic signed [42:0] dprod_q;
	logic [47:0]        pl_q;
	logic [47:0]        ph_q;
	logic               isign_q;
	logic signed [61:0] i_q;
	logic signed [43:0] d_q;

	logic [POWER_W-1:0]  power_out_q;
	logic                reverse_out_q;
	logic [SPEED_W-1:0]  speed_out_q;

	// Divider hookup.
	logic                 div_start;
	logic [DIV_REM_W-1:0] div_rem;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_REM_W-1:0] div_dvs;
	logic [DIV_CNT_W-1:0] div_steps;
	logic                 div_busy;
	logic [DIV_NUM_W-1:0] div_quo;

	// Combinational helpers.
	logic [39:0]         den;
	logic [DIV_NUM_W-1:0] dmag;
	logic signed [48:0]  isum;
	logic signed [47:0]  isat;
	logic [GAIN_W-1:0]   gi_mag;
	logic [47:0]         integ_mag;
	logic [71:0]         iprod;
	logic [60:0]         imag;
	logic [61:0]         imag_ext;
	logic [43:0]         dq_ext;
	logic signed [63:0]  psum;
	logic [25:0]         pclamp;
	logic [MSPEED_W-1:0] mmag;
	logic [POWER_W-1:0]  mpower;

	always_comb begin
		den       = {us_q, 16'h0000};
		dmag      = dprod_q[42] ? DIV_NUM_W'(-dprod_q) : DIV_NUM_W'(dprod_q);
		isum      = 49'(integ_q) + 49'(eu_q);
		// Saturate the integral to the 48-bit signed range.
		if (isum[48] != isum[47])
			isat = isum[48] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
		else
			isat = isum[47:0];
		gi_mag    = gain_i_q[GAIN_W-1] ? GAIN_W'(-gain_i_q) : GAIN_W'(gain_i_q);
		integ_mag = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);
		iprod     = {ph_q, 24'h000000} + {24'h000000, pl_q};
		imag      = (iprod > 72'(I_LIMIT)) ? I_LIMIT : iprod[60:0];
		imag_ext  = {1'b0, imag};
		dq_ext    = {1'b0, div_quo};
		psum      = $signed({38'h0, power_q}) + 64'(p_q) + 64'(i_q) + 64'(d_q);
		if (psum[63])
			pclamp = '0;
		else if (psum > $signed({38'h0, POWER_MAX}))
			pclamp = POWER_MAX;
		else
			pclamp = psum[25:0];
		mmag      = mspeed_q[MSPEED_W-1] ? MSPEED_W'(-mspeed_q) : MSPEED_W'(mspeed_q);
		mpower    = mmag[MSPEED_W-1] ? MPOWER_MAX : mmag[POWER_W-1:0];
	end

	// The speed division starts with the upper part of the numerator already
	// below the divisor, so sixteen steps give the whole quotient.
	always_comb begin
		div_start = (cmd.op == OP_SDIV) || (cmd.op == OP_IMUL);
		if (cmd.op == OP_SDIV) begin
			div_rem   = n_q[55:16];
			div_num   = {n_q[15:0], 27'h0};
			div_dvs   = den;
			div_steps = SPD_STEPS;
		end else begin
			div_rem   = '0;
			div_num   = dmag;
			div_dvs   = {16'h0000, us_q};
			div_steps = DER_STEPS;
		end
	end

	wspc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.num      (div_num),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			scale_q      <= SCALE_RESET;
			manual_q     <= 1'b0;
			mspeed_q     <= '0;
			prev_pulse_q <= '0;
			integ_q      <= '0;
			prev_err_q   <= '0;
			power_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
					REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
					REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
					REG_MANUAL: manual_q <= cfg_data[0];
					REG_MSPEED: mspeed_q <= cfg_data[MSPEED_W-1:0];
					default: ;
				endcase
			end
			if (cmd.capture && !manual_q)
				prev_pulse_q <= pulse_total;
			if (cmd.op == OP_INTEG) begin
				integ_q    <= isat;
				prev_err_q <= e_q;
			end
			if (cmd.op == OP_SUM)
				power_q <= pclamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			us_q <= (elapsed_us == '0) ? US_W'(1) : elapsed_us;
			dp_q <= pulse_total - prev_pulse_q;
		end
		unique case (cmd.op)
			OP_NONE: ;
			OP_PROD: prod_q <= 64'(dp_q) * 64'(scale_q);
			OP_NORM: begin
				sat1_q <= prod_q >= 64'(den);
				n_q    <= 60'(prod_q[39:0]) * 60'(USEC_PER_SEC);
			end
			OP_SDIV: sat_q <= sat1_q || (n_q[59:16] >= 44'(den));
			OP_TAKE_SPD: spd_q <= sat_q ? {SPEED_W{1'b1}} : div_quo[SPEED_W-1:0];
			OP_ERR: e_q <= 18'(target_q) - $signed({2'b00, spd_q});
			OP_EMUL: begin
				eu_q <= 43'(e_q) * 43'($signed({1'b0, us_q}));
				p_q  <= 42'(gain_p_q) * 42'(e_q);
				de_q <= 19'(e_q) - 19'(prev_err_q);
			end
			OP_INTEG: dprod_q <= 43'(gain_d_q) * 43'(de_q);
			OP_IMUL: begin
				pl_q    <= 48'(gi_mag) * 48'(integ_mag[23:0]);
				ph_q    <= 48'(gi_mag) * 48'(integ_mag[47:24]);
				isign_q <= gain_i_q[GAIN_W-1] ^ integ_q[47];
			end
			OP_ICOMB: i_q <= isign_q ? -imag_ext : imag_ext;
			OP_TAKE_D: d_q <= dprod_q[42] ? -dq_ext : dq_ext;
			OP_SUM: ;
			default: ;
		endcase
		if (cmd.out_load) begin
			power_out_q   <= manual_q ? mpower : power_q[25:16];
			reverse_out_q <= manual_q && mspeed_q[MSPEED_W-1];
			speed_out_q   <= manual_q ? '0 : spd_q;
		end
	end

	assign sts.manual     = manual_q;
	assign sts.div_busy   = div_busy;
	assign motor_power    = power_out_q;
	assign motor_reverse  = reverse_out_q;
	assign measured_speed = speed_out_q;

endmodule

[hdl/wspc_ctrl.sv]
// Sequencing state machine of the wheel speed PID controller.
// Depends on wspc_pkg for the command and status structs.
module wspc_ctrl import wspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	input  sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROD,
		S_NORM,
		S_SDIV,
		S_SWAIT,
		S_SPD,
		S_ERR,
		S_EMUL,
		S_INTEG,
		S_IMUL,
		S_ICOMB,
		S_DWAIT,
		S_DTAKE,
		S_SUM,
		S_OUT
	} state_t;

	state_t state_q;
	dp_op_t op_q;
	logic   out_valid_q;
	logic   out_load;
	logic   idle_ready;

	// The result register is reloaded only once the previous item has left.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// No tick is taken while reset is held.
	assign idle_ready = arst_n && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !sts.manual) begin
						state_q <= S_PROD;
						op_q    <= OP_PROD;
					end else begin
						if (in_valid)
							state_q <= S_OUT;
						op_q <= OP_NONE;
					end
				end
				S_PROD: begin
					state_q <= S_NORM;
					op_q    <= OP_NORM;
				end
				S_NORM: begin
					state_q <= S_SDIV;
					op_q    <= OP_SDIV;
				end
				S_SDIV: begin
					state_q <= S_SWAIT;
					op_q    <= OP_NONE;
				end
				S_SWAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_SPD;
						op_q    <= OP_TAKE_SPD;
					end else begin
						op_q <= OP_NONE;
					end
				end
				S_SPD: begin
					state_q <= S_ERR;
					op_q    <= OP_ERR;
				end
				S_ERR: begin
					state_q <= S_EMUL;
					op_q    <= OP_EMUL;
				end
				S_EMUL: begin
					state_q <= S_INTEG;
					op_q    <= OP_INTEG;
				end
				S_INTEG: begin
					state_q <= S_IMUL;
					op_q    <= OP_IMUL;
				end
				S_IMUL: begin
					state_q <= S_ICOMB;
					op_q    <= OP_ICOMB;
				end
				S_ICOMB: begin
					state_q <= S_DWAIT;
					op_q    <= OP_NONE;
				end
				S_DWAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_DTAKE;
						op_q    <= OP_TAKE_D;
					end else begin
						op_q <= OP_NONE;
					end
				end
				S_DTAKE: begin
					state_q <= S_SUM;
					op_q    <= OP_SUM;
				end
				S_SUM: begin
					state_q <= S_OUT;
					op_q    <= OP_NONE;
				end
				S_OUT: begin
					op_q <= OP_NONE;
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= OP_NONE;
				end
			endcase
		end
	end

	assign in_ready     = idle_ready;
	assign out_valid    = out_valid_q;
	assign cmd.capture  = in_valid && idle_ready;
	assign cmd.op       = op_q;
	assign cmd.out_load = out_load;

endmodule

[hdl/wheel_speed_pid_controller.sv]
// Wheel speed PID controller top level: joins wspc_ctrl and wspc_datapath.
// Depends on wspc_pkg and the channel interfaces in wspc_if.sv.
//
// Each item on the tick channel is one control tick carrying the running
// hall pulse total and the microseconds since the previous tick. For every
// tick one item leaves on the result channel: motor power, direction and the
// measured wheel speed. Registers are written on the cfg channel, which is
// ready whenever reset is released; write them only while no tick is in flight.
// In automatic mode the tick goes through a chain of single steps and two runs
// of the shared divider, one for the speed and one for the derivative term; in
// manual mode it goes straight to the output register. One tick is worked on
// at a time; the next is accepted once the result has been loaded into the
// output register, even while that result still waits for the receiver. A
// stalled receiver holds the finished result and blocks the following tick
// only once it is fully computed. Reset clears the configuration to its
// defaults (speed scale 1.0, others zero), clears the controller state, drops
// the result valid output and holds both ready outputs low.
module wheel_speed_pid_controller import wspc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	wspc_tick_if.sink            tick,
	wspc_result_if.source        result,
	wspc_cfg_if.sink             cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = arst_n;

	wspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	wspc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.pulse_total    (tick.pulse_total),
		.elapsed_us     (tick.elapsed_us),
		.sts            (sts),
		.motor_power    (result.motor_power),
		.motor_reverse  (result.motor_reverse),
		.measured_speed (result.measured_speed)
	);

`ifndef ASSERT_OFF
	a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("tick accepted while another is in flight");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !tick.ready)
		else $error("input ready while the divider is busy");

	a_reverse_only_manual: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.motor_reverse |-> result.measured_speed == '0)
		else $error("reverse drive reported with a measured speed");
`endif

endmodule
